FILE: rtl/ips_pkg.sv
package ips_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned OWNER_W    = 6;
    localparam int unsigned RES_W      = 7;
    localparam logic [RES_W-1:0] RES_LIMIT = 7'd64;

    typedef struct packed {
        logic              first;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
    } in_item_t;

    typedef struct packed {
        logic [OWNER_W-1:0] assigned_resource;
        logic [RES_W-1:0]   resources_used;
        logic               overflow;
    } out_item_t;

    // One heap slot: end time and the resource holding it.
    typedef struct packed {
        logic [TIME_W-1:0]  end_time;
        logic [OWNER_W-1:0] owner;
    } heap_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT,
        ST_SIFT_DOWN,
        ST_INSERT,
        ST_SIFT_UP,
        ST_PLACE,
        ST_DONE
    } ctrl_state_t;

endpackage

FILE: rtl/ips_heap_ram.sv
module ips_heap_ram
    import ips_pkg::*;
#(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  heap_entry_t   wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output heap_entry_t   rdata_a,
    output heap_entry_t   rdata_b
);

    heap_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: rtl/ips_ctrl.sv
module ips_ctrl
    import ips_pkg::*;
#(
    parameter int unsigned CAPACITY = 64,
    parameter int unsigned AW       = 6,
    parameter int unsigned CW       = 7
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  in_item_t      in_data,
    output logic          res_valid,
    input  logic          res_ready,
    output out_item_t     res_data,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output heap_entry_t   mem_wdata,
    output logic [AW-1:0] mem_raddr_a,
    output logic [AW-1:0] mem_raddr_b,
    input  heap_entry_t   mem_rdata_a,
    input  heap_entry_t   mem_rdata_b
);

    // Child indices can reach twice the depth, so they carry two spare bits.
    localparam int unsigned IW = AW + 2;

    ctrl_state_t         state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [RES_W-1:0]    next_res_reg, next_res_next;
    logic [TIME_W-1:0]   start_reg, start_next;
    heap_entry_t         new_reg, new_next;
    heap_entry_t         move_reg, move_next;
    logic [AW-1:0]       hole_reg, hole_next;
    logic [CW-1:0]       size_reg, size_next;
    logic [OWNER_W-1:0]  assigned_reg, assigned_next;
    logic                ovf_reg, ovf_next;

    logic [CW-1:0]       cnt_eff;
    logic [IW-1:0]       l_idx, r_idx, nl_idx, nr_idx;
    logic                l_ok, r_ok, take_l, take_r;
    logic [TIME_W-1:0]   s_end;
    logic [AW-1:0]       parent, grand;
    logic [AW-1:0]       sd_hole;

    assign l_idx  = {1'b0, hole_reg, 1'b1};
    assign r_idx  = l_idx + IW'(1);
    assign l_ok   = l_idx < IW'(size_reg);
    assign r_ok   = r_idx < IW'(size_reg);
    assign take_l = l_ok && (move_reg.end_time > mem_rdata_a.end_time);
    assign s_end  = take_l ? mem_rdata_a.end_time : move_reg.end_time;
    assign take_r = r_ok && (s_end > mem_rdata_b.end_time);
    assign sd_hole = take_r ? r_idx[AW-1:0] : l_idx[AW-1:0];
    assign nl_idx = {1'b0, sd_hole, 1'b1};
    assign nr_idx = nl_idx + IW'(1);

    assign parent = AW'((hole_reg - AW'(1)) >> 1);
    assign grand  = AW'((parent - AW'(1)) >> 1);

    assign cnt_eff = in_data.first ? '0 : count_reg;

    assign res_data.assigned_resource = assigned_reg;
    assign res_data.resources_used    = next_res_reg;
    assign res_data.overflow          = ovf_reg;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        next_res_next = next_res_reg;
        start_next    = start_reg;
        new_next      = new_reg;
        move_next     = move_reg;
        hole_next     = hole_reg;
        size_next     = size_reg;
        assigned_next = assigned_reg;
        ovf_next      = ovf_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = hole_reg;
        mem_wdata     = new_reg;
        mem_raddr_a   = '0;
        mem_raddr_b   = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                mem_raddr_b = AW'(cnt_eff - CW'(1));
                if (in_valid)
                begin
                    count_next        = cnt_eff;
                    next_res_next     = in_data.first ? '0 : next_res_reg;
                    start_next        = in_data.start_time;
                    new_next.end_time = in_data.end_time;
                    state_next        = ST_ROOT;
                end
            end

            ST_ROOT:
            begin
                if (count_reg != '0 && start_reg >= mem_rdata_a.end_time)
                begin
                    // Reuse: pull the root, last entry restarts from the top.
                    assigned_next  = mem_rdata_a.owner;
                    new_next.owner = mem_rdata_a.owner;
                    ovf_next       = 1'b0;
                    size_next      = count_reg - CW'(1);
                    move_next      = mem_rdata_b;
                    hole_next      = '0;
                    if (count_reg != CW'(1))
                    begin
                        mem_raddr_a = AW'(1);
                        mem_raddr_b = AW'(2);
                        state_next  = ST_SIFT_DOWN;
                    end
                    else
                    begin
                        state_next = ST_INSERT;
                    end
                end
                else if (count_reg >= CW'(CAPACITY) || next_res_reg >= RES_LIMIT)
                begin
                    assigned_next = '0;
                    ovf_next      = 1'b1;
                    state_next    = ST_DONE;
                end
                else
                begin
                    assigned_next  = next_res_reg[OWNER_W-1:0];
                    new_next.owner = next_res_reg[OWNER_W-1:0];
                    ovf_next       = 1'b0;
                    hole_next      = count_reg[AW-1:0];
                    count_next     = count_reg + CW'(1);
                    next_res_next  = next_res_reg + RES_W'(1);
                    state_next     = ST_INSERT;
                end
            end

            ST_SIFT_DOWN:
            begin
                mem_we = 1'b1;
                if (take_r || take_l)
                begin
                    mem_wdata   = take_r ? mem_rdata_b : mem_rdata_a;
                    hole_next   = sd_hole;
                    mem_raddr_a = nl_idx[AW-1:0];
                    mem_raddr_b = nr_idx[AW-1:0];
                end
                else
                begin
                    // The moving entry settles; the insert starts at the tail.
                    mem_wdata  = move_reg;
                    hole_next  = size_reg[AW-1:0];
                    state_next = ST_INSERT;
                end
            end

            ST_INSERT:
            begin
                mem_raddr_a = parent;
                state_next  = (hole_reg == '0) ? ST_PLACE : ST_SIFT_UP;
            end

            ST_SIFT_UP:
            begin
                mem_we = 1'b1;
                if (mem_rdata_a.end_time > new_reg.end_time)
                begin
                    mem_wdata   = mem_rdata_a;
                    hole_next   = parent;
                    mem_raddr_a = grand;
                    if (parent == '0)
                    begin
                        state_next = ST_PLACE;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_PLACE:
            begin
                mem_we     = 1'b1;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            next_res_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            next_res_reg <= next_res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg    <= start_next;
        new_reg      <= new_next;
        move_reg     <= move_next;
        hole_reg     <= hole_next;
        size_reg     <= size_next;
        assigned_reg <= assigned_next;
        ovf_reg      <= ovf_next;
    end

endmodule

FILE: rtl/interval_partition_scheduler_core.sv
// Greedy interval partitioning over a binary min-heap of end times.
// Input channel (in_valid/in_ready/in_data): one interval per transfer, in
// non-decreasing start order; setting first clears the heap and the resource
// counter before that interval is handled.
// Output channel (out_valid/out_ready/out_data): exactly one result per
// interval, in order: the resource given, the number of resources opened so
// far, and an overflow flag when a new resource was needed but none was left.
// Throughput: one interval at a time. After its transfer an interval is checked
// against the heap root; an overflow goes straight to its result, otherwise
// the heap is updated by sift-down and sift-up, one heap level per cycle
// through the two-read, one-write heap memory, until its result is registered.
// The next interval is taken the cycle after that.
// Results sit in an output register, so the next interval is taken while
// a result waits; if the receiver stalls longer, the block holds its next
// result until the output register frees.
// Reset empties the heap and the resource counter at once; no clearing
// pass is needed because only entries below the fill count are used.
module interval_partition_scheduler_core
    import ips_pkg::*;
#(
    parameter int unsigned CAPACITY = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic          res_valid, res_ready;
    out_item_t     res_data;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;
    heap_entry_t   mem_wdata, mem_rdata_a, mem_rdata_b;

    logic          out_valid_reg, out_valid_next;
    out_item_t     out_data_reg;

    ips_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr_a (mem_raddr_a),
        .mem_raddr_b (mem_raddr_b),
        .mem_rdata_a (mem_rdata_a),
        .mem_rdata_b (mem_rdata_b)
    );

    ips_heap_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_heap (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    // The output register takes a new result when empty or when its current
    // result is transferred in the same cycle.
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
